// ===== src/necir_pkg.sv =====
`timescale 1ns / 1ps

package necir_pkg;

  // frame geometry
  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned BYTE_W     = 8;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX    = 3'd7;

  // window bounds after reset, in ticks
  localparam logic [TICK_W-1:0] RST_LEADER_MIN = 16'd12150;
  localparam logic [TICK_W-1:0] RST_LEADER_MAX = 16'd14850;
  localparam logic [TICK_W-1:0] RST_REPEAT_MIN = 16'd10125;
  localparam logic [TICK_W-1:0] RST_REPEAT_MAX = 16'd12149;
  localparam logic [TICK_W-1:0] RST_ZERO_MIN   = 16'd675;
  localparam logic [TICK_W-1:0] RST_ZERO_MAX   = 16'd1575;
  localparam logic [TICK_W-1:0] RST_ONE_MIN    = 16'd1576;
  localparam logic [TICK_W-1:0] RST_ONE_MAX    = 16'd2925;

  // all timing windows, bounds inclusive
  typedef struct packed {
    logic [TICK_W-1:0] leader_min;
    logic [TICK_W-1:0] leader_max;
    logic [TICK_W-1:0] repeat_min;
    logic [TICK_W-1:0] repeat_max;
    logic [TICK_W-1:0] zero_min;
    logic [TICK_W-1:0] zero_max;
    logic [TICK_W-1:0] one_min;
    logic [TICK_W-1:0] one_max;
  } cfg_t;

  // which windows an edge period falls into
  typedef struct packed {
    logic leader_hit;
    logic repeat_hit;
    logic zero_hit;
    logic one_hit;
  } hits_t;

endpackage

// ===== src/nec_ir_frame_decoder_top.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// in        input      in_valid / in_ready  interval_ticks, overflowed
// out       output     out_valid/out_ready  address, command, is_repeat
// cfg       input      cfg_we (no wait)     cfg_index, cfg_data
//
// one edge per cycle while the output drains; an edge is held in an input
// register, then the state update and result land in the output register.
// reset: windows return to nominal bounds, decoder idle, no repeat allowed.
// a result waiting on out_ready holds the input register; in_ready drops only
// while that register is full and cannot drain.

module nec_ir_frame_decoder_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [necir_pkg::TICK_W-1:0]      interval_ticks,
  input  logic                              overflowed,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [necir_pkg::BYTE_W-1:0]      address,
  output logic [necir_pkg::BYTE_W-1:0]      command,
  output logic                              is_repeat,
  input  logic                              cfg_we,
  input  logic [necir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [necir_pkg::TICK_W-1:0]      cfg_data
);
  import necir_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WAIT,
    MODE_RECV,
    MODE_DONE
  } mode_t;

  cfg_t                  cfg;
  hits_t                 hits;

  logic                  s1_valid;
  logic [TICK_W-1:0]     s1_ticks;
  logic                  s1_ovf;
  logic                  s1_go;

  mode_t                 mode;
  mode_t                 mode_next;
  logic [COUNT_W-1:0]    bit_count;
  logic [COUNT_W-1:0]    bit_count_next;
  logic [FRAME_BITS-1:0] shift_word;
  logic [FRAME_BITS-1:0] shift_word_next;
  logic [BYTE_W-1:0]     last_address;
  logic [BYTE_W-1:0]     last_command;
  logic                  repeat_allowed;
  logic                  repeat_allowed_next;
  logic                  save_frame;

  logic                  emit;
  logic                  emit_rep;
  logic [BYTE_W-1:0]     emit_addr;
  logic [BYTE_W-1:0]     emit_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_min <= RST_LEADER_MIN;
      cfg.leader_max <= RST_LEADER_MAX;
      cfg.repeat_min <= RST_REPEAT_MIN;
      cfg.repeat_max <= RST_REPEAT_MAX;
      cfg.zero_min   <= RST_ZERO_MIN;
      cfg.zero_max   <= RST_ZERO_MAX;
      cfg.one_min    <= RST_ONE_MIN;
      cfg.one_max    <= RST_ONE_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEADER_MIN: cfg.leader_min <= cfg_data;
        REG_LEADER_MAX: cfg.leader_max <= cfg_data;
        REG_REPEAT_MIN: cfg.repeat_min <= cfg_data;
        REG_REPEAT_MAX: cfg.repeat_max <= cfg_data;
        REG_ZERO_MIN:   cfg.zero_min   <= cfg_data;
        REG_ZERO_MAX:   cfg.zero_max   <= cfg_data;
        REG_ONE_MIN:    cfg.one_min    <= cfg_data;
        REG_ONE_MAX:    cfg.one_max    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register drains whenever the output register can take a beat
  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ticks <= interval_ticks;
      s1_ovf   <= overflowed;
    end
  end

  necir_window u_window (
    .ticks (s1_ticks),
    .cfg   (cfg),
    .hits  (hits)
  );

  // per-edge decode
  always_comb begin
    logic                  bit_val;
    logic [FRAME_BITS-1:0] word;
    logic                  frame_ok;

    mode_next           = mode;
    bit_count_next      = bit_count;
    shift_word_next     = shift_word;
    repeat_allowed_next = repeat_allowed;
    save_frame          = 1'b0;
    emit                = 1'b0;
    emit_rep            = 1'b0;
    emit_addr           = last_address;
    emit_cmd            = last_command;
    bit_val             = hits.one_hit && !hits.zero_hit;
    word                = {shift_word[FRAME_BITS-2:0], bit_val};
    frame_ok            = ((word[31:24] ^ word[23:16]) == 8'hFF) &&
                          ((word[15:8] ^ word[7:0]) == 8'hFF);

    case (mode)
      MODE_WAIT: begin
        if (s1_ovf) begin
          mode_next = MODE_IDLE;
        end else if (hits.leader_hit) begin
          bit_count_next      = '0;
          shift_word_next     = '0;
          repeat_allowed_next = 1'b0;
          mode_next           = MODE_RECV;
        end else if (hits.repeat_hit && repeat_allowed) begin
          emit      = 1'b1;
          emit_rep  = 1'b1;
          mode_next = MODE_DONE;
        end else begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_RECV: begin
        if (s1_ovf || !(hits.zero_hit || hits.one_hit)) begin
          mode_next = MODE_IDLE;
        end else begin
          shift_word_next = word;
          bit_count_next  = bit_count + 1'b1;
          // check byte pairs on the last bit
          if (bit_count_next >= COUNT_W'(FRAME_BITS)) begin
            if (frame_ok) begin
              emit                = 1'b1;
              emit_addr           = word[31:24];
              emit_cmd            = word[15:8];
              save_frame          = 1'b1;
              repeat_allowed_next = 1'b1;
              mode_next           = MODE_DONE;
            end else begin
              repeat_allowed_next = 1'b0;
              mode_next           = MODE_IDLE;
            end
          end
        end
      end
      default: begin
        // idle or done: this edge opens a leader mark
        mode_next = MODE_WAIT;
      end
    endcase
  end

  // decoder state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      bit_count      <= '0;
      shift_word     <= '0;
      last_address   <= '0;
      last_command   <= '0;
      repeat_allowed <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (s1_go) begin
        mode           <= mode_next;
        bit_count      <= bit_count_next;
        shift_word     <= shift_word_next;
        repeat_allowed <= repeat_allowed_next;
        if (save_frame) begin
          last_address <= emit_addr;
          last_command <= emit_cmd;
        end
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      address   <= emit_addr;
      command   <= emit_cmd;
      is_repeat <= emit_rep;
    end
  end

  // a result always leaves the decoder in done
  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (s1_go && emit) |=> (mode == MODE_DONE))
    else $error("result emitted without entering done");

  // a repeat result needs an earlier good frame
  a_repeat_allowed: assert property (@(posedge clk) disable iff (rst)
    (s1_go && emit && emit_rep) |-> (repeat_allowed && mode == MODE_WAIT))
    else $error("repeat emitted without a stored frame");

  // a full frame result arms repeats and stores its bytes
  a_frame_store: assert property (@(posedge clk) disable iff (rst)
    (s1_go && emit && !emit_rep) |=> (repeat_allowed && last_address == address &&
                                      last_command == command))
    else $error("frame result not stored");

  // bit counter never passes the frame length while receiving
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_RECV) |-> (bit_count < COUNT_W'(FRAME_BITS)))
    else $error("bit counter overran frame");

endmodule

// ===== src/necir_window.sv =====
`timescale 1ns / 1ps

module necir_window (
  input  logic [necir_pkg::TICK_W-1:0] ticks,
  input  necir_pkg::cfg_t              cfg,
  output necir_pkg::hits_t             hits
);
  import necir_pkg::*;

  // inclusive range checks, an empty window (min above max) never hits
  always_comb begin
    hits.leader_hit = (ticks >= cfg.leader_min) && (ticks <= cfg.leader_max);
    hits.repeat_hit = (ticks >= cfg.repeat_min) && (ticks <= cfg.repeat_max);
    hits.zero_hit   = (ticks >= cfg.zero_min)   && (ticks <= cfg.zero_max);
    hits.one_hit    = (ticks >= cfg.one_min)    && (ticks <= cfg.one_max);
  end

endmodule
